// ----- src/dscs_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive and steering command shaper package
// Shared widths, register indexes, sequencer states and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package dscs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int XW  = 42;
    localparam int ZW  = 26;
    localparam int MAW = 40;
    localparam int MBW = 13;

    localparam logic signed [ZW-1:0] DEG90 = 26'sd5898240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_FRONT = 3'd0,
        CFG_DRIVE_REAR  = 3'd1,
        CFG_TORQUE_LIM  = 3'd2,
        CFG_SLEW_RATE   = 3'd3,
        CFG_MAX_STEER   = 3'd4,
        CFG_WHEELBASE   = 3'd5,
        CFG_TRACK_WIDTH = 3'd6
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MSTEP,
        S_SLEW,
        S_MTORQ,
        S_TORQ,
        S_MANG,
        S_ANG,
        S_ROT,
        S_ROTF,
        S_MWS,
        S_MWSF,
        S_MTC,
        S_MTCF,
        S_MTS,
        S_VSET,
        S_VEC,
        S_VFIN,
        S_OUT
    } t_state;

    function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            4'd0:  v = 26'sd2949120;
            4'd1:  v = 26'sd1740967;
            4'd2:  v = 26'sd919879;
            4'd3:  v = 26'sd466945;
            4'd4:  v = 26'sd234379;
            4'd5:  v = 26'sd117304;
            4'd6:  v = 26'sd58666;
            4'd7:  v = 26'sd29335;
            4'd8:  v = 26'sd14668;
            4'd9:  v = 26'sd7334;
            4'd10: v = 26'sd3667;
            4'd11: v = 26'sd1833;
            4'd12: v = 26'sd917;
            4'd13: v = 26'sd458;
            4'd14: v = 26'sd229;
            4'd15: v = 26'sd115;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/dscs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Carries one driver command word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dscs_cmd_if;
    logic               valid;
    logic               ready;
    logic [15:0]        time_step;
    logic signed [15:0] target_throttle;
    logic signed [15:0] target_steering;
    logic [14:0]        handbrake_level;

    modport source (
        output valid, time_step, target_throttle, target_steering, handbrake_level,
        input  ready
    );
    modport sink (
        input  valid, time_step, target_throttle, target_steering, handbrake_level,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/dscs_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Carries one torque and wheel angle word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dscs_res_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] front_torque;
    logic signed [16:0] rear_torque;
    logic               rear_locked;
    logic signed [15:0] left_steer_angle;
    logic signed [15:0] right_steer_angle;

    modport source (
        output valid, front_torque, rear_torque, rear_locked, left_steer_angle,
               right_steer_angle,
        input  ready
    );
    modport sink (
        input  valid, front_torque, rear_torque, rear_locked, left_steer_angle,
               right_steer_angle,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/drive_steer_command_shaper_core.sv -----
// ----------------------------------------------------------------------------
// Drive and steering command shaper
// Slews throttle and steering, splits drive torque and computes Ackermann angles.
// ----------------------------------------------------------------------------
// A command word enters on i_cmd; one result word leaves on o_res for each.
// Configuration is written through i_cfg_wr_en, i_cfg_idx and i_cfg_data;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. Indexes beyond the register list are ignored.
// One word is processed at a time. All products go through one shift-add
// multiplier that handles one multiplier bit per cycle, and the wheel angle
// uses one shared CORDIC stage for 16 rotation and 16 vectoring iterations.
// A word with a zero inner wheel angle or track width skips the CORDIC and
// the later products; the next word is taken once its result is registered.
// The result sits in an output register, so a new command is taken as soon
// as the sequencer is idle even if the receiver stalls; a second result
// waits in the sequencer until the first one is taken.
// Reset restores the register defaults, zeroes throttle and steering and
// drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_steer_command_shaper_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [dscs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dscs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dscs_cmd_if.sink                            i_cmd,
    dscs_res_if.source                          o_res
);
    import dscs_pkg::*;

    t_state r_state, n_state;

    logic        r_drive_front, r_drive_rear;
    logic [11:0] r_torque_lim;
    logic [7:0]  r_slew_rate;
    logic [6:0]  r_max_steer;
    logic [12:0] r_wheelbase, r_track;

    logic signed [15:0] r_thr, n_thr, r_str, n_str;
    logic               r_ov, n_ov;

    logic signed [15:0] r_tt, n_tt, r_tsr, n_tsr;
    logic               r_lock, n_lock;
    logic [MAW-1:0]     r_ma, n_ma, r_acc, n_acc;
    logic [MBW-1:0]     r_mb, n_mb;
    logic [3:0]         r_cnt, n_cnt;
    logic signed [16:0] r_ft, n_ft, r_rt, n_rt;
    logic [14:0]        r_a, n_a, r_b, n_b;
    logic               r_hi, n_hi;
    logic signed [XW-1:0] r_x, n_x, r_y, n_y, r_px, n_px;
    logic signed [ZW-1:0] r_z, n_z;
    logic [3:0]         r_i, n_i;
    logic signed [ZW-1:0] r_c, n_c;
    logic [24:0]        r_s, n_s;

    logic signed [16:0] r_o_ft, n_o_ft, r_o_rt, n_o_rt;
    logic               r_o_lock, n_o_lock;
    logic signed [15:0] r_o_left, n_o_left, r_o_right, n_o_right;

    logic [MAW-1:0]       w_madd;
    logic                 w_mdone;
    logic signed [XW-1:0] w_xs, w_ys, w_cx, w_cy;
    logic signed [ZW-1:0] w_at, w_cz;
    logic                 w_ccw;
    logic [15:0]          w_str_mag;
    logic [28:0]          w_tsum;
    logic [16:0]          w_q;
    logic [22:0]          w_asum;
    logic [14:0]          w_a;
    logic [22:0]          w_zin;
    logic signed [XW-1:0] w_c_full, w_s_full;
    logic signed [XW-1:0] w_prod;
    logic signed [ZW-1:0] w_zr;
    logic                 w_pos;

    function automatic logic signed [15:0] slew(input logic signed [15:0] now,
                                                input logic signed [15:0] tgt,
                                                input logic [22:0] step);
        logic signed [24:0] d;
        logic signed [24:0] s;
        logic signed [24:0] r;
        d = 25'(tgt) - 25'(now);
        s = signed'({2'b00, step});
        if (d > s) begin
            d = s;
        end else if (d < -s) begin
            d = -s;
        end
        r = 25'(now) + d;
        return r[15:0];
    endfunction

    assign i_cmd.ready             = (r_state == S_IDLE);
    assign o_res.valid             = r_ov;
    assign o_res.front_torque      = r_o_ft;
    assign o_res.rear_torque       = r_o_rt;
    assign o_res.rear_locked       = r_o_lock;
    assign o_res.left_steer_angle  = r_o_left;
    assign o_res.right_steer_angle = r_o_right;

    assign w_madd  = r_mb[0] ? (r_acc + r_ma) : r_acc;
    assign w_mdone = (r_cnt == 4'd0);

    assign w_xs  = r_x >>> r_i;
    assign w_ys  = r_y >>> r_i;
    assign w_at  = atan_lut(r_i);
    assign w_ccw = (r_state == S_ROT) ? ~r_z[ZW-1] : r_y[XW-1];
    assign w_cx  = w_ccw ? (r_x - w_ys) : (r_x + w_ys);
    assign w_cy  = w_ccw ? (r_y + w_xs) : (r_y - w_xs);
    assign w_cz  = w_ccw ? (r_z - w_at) : (r_z + w_at);

    assign w_str_mag = r_str[15] ? (~r_str + 16'd1) : r_str;

    assign w_tsum = (r_drive_front && r_drive_rear) ? ({1'b0, r_acc[27:0]} + 29'd2048)
                                                    : ({1'b0, r_acc[27:0]} + 29'd1024);
    assign w_q    = (r_drive_front && r_drive_rear) ? w_tsum[28:12] : w_tsum[27:11];

    assign w_asum = r_acc[22:0] + 23'd64;
    assign w_a    = w_asum[21:7];
    assign w_zin  = {w_a, 8'd0};

    assign w_c_full = r_hi ? -r_y : r_x;
    assign w_s_full = r_hi ? r_x : r_y;
    assign w_prod   = signed'({2'b00, r_acc});

    assign w_zr  = (r_z + 26'sd128) >>> 8;
    assign w_pos = ~r_str[15] && (r_str != 16'sd0);

    always_comb begin
        n_state   = r_state;
        n_thr     = r_thr;
        n_str     = r_str;
        n_ov      = r_ov;
        n_tt      = r_tt;
        n_tsr     = r_tsr;
        n_lock    = r_lock;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_ft      = r_ft;
        n_rt      = r_rt;
        n_a       = r_a;
        n_b       = r_b;
        n_hi      = r_hi;
        n_x       = r_x;
        n_y       = r_y;
        n_px      = r_px;
        n_z       = r_z;
        n_i       = r_i;
        n_c       = r_c;
        n_s       = r_s;
        n_o_ft    = r_o_ft;
        n_o_rt    = r_o_rt;
        n_o_lock  = r_o_lock;
        n_o_left  = r_o_left;
        n_o_right = r_o_right;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_tt    = i_cmd.target_throttle;
                    n_tsr   = i_cmd.target_steering;
                    n_lock  = (i_cmd.handbrake_level > 15'd16384);
                    n_ma    = MAW'(i_cmd.time_step);
                    n_mb    = MBW'(r_slew_rate);
                    n_acc   = '0;
                    n_cnt   = 4'd7;
                    n_state = S_MSTEP;
                end
            end
            S_MSTEP, S_MTORQ, S_MANG, S_MWS, S_MTC, S_MTS: begin
                n_acc = w_madd;
                n_ma  = r_ma << 1;
                n_mb  = r_mb >> 1;
                n_cnt = r_cnt - 4'd1;
                if (w_mdone) begin
                    unique case (r_state)
                        S_MSTEP: n_state = S_SLEW;
                        S_MTORQ: n_state = S_TORQ;
                        S_MANG:  n_state = S_ANG;
                        S_MWS:   n_state = S_MWSF;
                        S_MTC:   n_state = S_MTCF;
                        default: n_state = S_VSET;
                    endcase
                end
            end
            S_SLEW: begin
                n_thr   = slew(r_thr, r_tt, r_acc[23:1]);
                n_str   = slew(r_str, r_tsr, r_acc[23:1]);
                n_ma    = {{(MAW-16){1'b0}}, (n_thr[15] ? (~n_thr + 16'd1) : n_thr)};
                n_mb    = MBW'(r_torque_lim);
                n_acc   = '0;
                n_cnt   = 4'd11;
                n_state = S_MTORQ;
            end
            S_TORQ: begin
                n_ft    = r_drive_front ? (r_thr[15] ? -signed'(w_q) : signed'(w_q)) : 17'sd0;
                n_rt    = r_drive_rear ? (r_thr[15] ? -signed'(w_q) : signed'(w_q)) : 17'sd0;
                n_ma    = MAW'(w_str_mag);
                n_mb    = MBW'(r_max_steer);
                n_acc   = '0;
                n_cnt   = 4'd6;
                n_state = S_MANG;
            end
            S_ANG: begin
                n_a  = w_a;
                n_x  = XW'(64'sd16777216);
                n_y  = '0;
                n_i  = 4'd0;
                n_hi = (signed'({3'b000, w_zin}) > DEG90);
                n_z  = n_hi ? (signed'({3'b000, w_zin}) - DEG90) : signed'({3'b000, w_zin});
                if ((w_a == 15'd0) || (r_track == 13'd0)) begin
                    n_b     = 15'd0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_ROT;
                end
            end
            S_ROT, S_VEC: begin
                n_x = w_cx;
                n_y = w_cy;
                n_z = w_cz;
                n_i = r_i + 4'd1;
                if (r_i == 4'd15) begin
                    n_state = (r_state == S_ROT) ? S_ROTF : S_VFIN;
                end
            end
            S_ROTF: begin
                n_c     = w_c_full[ZW-1:0];
                n_s     = w_s_full[XW-1] ? 25'd0 : w_s_full[24:0];
                n_ma    = MAW'(n_s);
                n_mb    = r_wheelbase;
                n_acc   = '0;
                n_cnt   = 4'd12;
                n_state = S_MWS;
            end
            S_MWSF: begin
                n_px    = w_prod;
                n_ma    = MAW'(r_c[ZW-1] ? -r_c : r_c);
                n_mb    = r_track;
                n_acc   = '0;
                n_cnt   = 4'd12;
                n_state = S_MTC;
            end
            S_MTCF: begin
                n_px    = r_c[ZW-1] ? (r_px - w_prod) : (r_px + w_prod);
                n_ma    = MAW'(r_s);
                n_mb    = r_track;
                n_acc   = '0;
                n_cnt   = 4'd12;
                n_state = S_MTS;
            end
            S_VSET: begin
                n_i = 4'd0;
                if (r_px[XW-1]) begin
                    n_x = w_prod;
                    n_y = -r_px;
                    n_z = DEG90;
                end else begin
                    n_x = r_px;
                    n_y = w_prod;
                    n_z = '0;
                end
                n_state = S_VEC;
            end
            S_VFIN: begin
                if (w_zr[ZW-1]) begin
                    n_b = 15'd0;
                end else if (w_zr > 26'sd32767) begin
                    n_b = 15'd32767;
                end else begin
                    n_b = w_zr[14:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || o_res.ready) begin
                    n_ov      = 1'b1;
                    n_o_ft    = r_ft;
                    n_o_rt    = r_rt;
                    n_o_lock  = r_lock;
                    n_o_left  = w_pos ? signed'({1'b0, r_a}) : -signed'({1'b0, r_a});
                    n_o_right = w_pos ? signed'({1'b0, r_b}) : -signed'({1'b0, r_b});
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_thr         <= '0;
            r_str         <= '0;
            r_ov          <= 1'b0;
            r_drive_front <= 1'b1;
            r_drive_rear  <= 1'b1;
            r_torque_lim  <= 12'd1200;
            r_slew_rate   <= 8'd4;
            r_max_steer   <= 7'd30;
            r_wheelbase   <= 13'd2440;
            r_track       <= 13'd1840;
        end else begin
            r_state <= n_state;
            r_thr   <= n_thr;
            r_str   <= n_str;
            r_ov    <= n_ov;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DRIVE_FRONT: r_drive_front <= i_cfg_data[0];
                    CFG_DRIVE_REAR:  r_drive_rear  <= i_cfg_data[0];
                    CFG_TORQUE_LIM:  r_torque_lim  <= i_cfg_data[11:0];
                    CFG_SLEW_RATE:   r_slew_rate   <= i_cfg_data[7:0];
                    CFG_MAX_STEER:   r_max_steer   <= i_cfg_data[6:0];
                    CFG_WHEELBASE:   r_wheelbase   <= i_cfg_data;
                    CFG_TRACK_WIDTH: r_track       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tt      <= n_tt;
        r_tsr     <= n_tsr;
        r_lock    <= n_lock;
        r_ma      <= n_ma;
        r_mb      <= n_mb;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_ft      <= n_ft;
        r_rt      <= n_rt;
        r_a       <= n_a;
        r_b       <= n_b;
        r_hi      <= n_hi;
        r_x       <= n_x;
        r_y       <= n_y;
        r_px      <= n_px;
        r_z       <= n_z;
        r_i       <= n_i;
        r_c       <= n_c;
        r_s       <= n_s;
        r_o_ft    <= n_o_ft;
        r_o_rt    <= n_o_rt;
        r_o_lock  <= n_o_lock;
        r_o_left  <= n_o_left;
        r_o_right <= n_o_right;
    end

endmodule

`default_nettype wire
